/* src/ksv_pkg.sv */
// shared types and constants of the knn shapley recursion unit
// used by every file in src but ksv_ram; no dependencies of its own
package ksv_pkg;

	// field widths fixed by the item and result formats
	localparam int IDX_W = 10;
	localparam int LAB_W = 8;
	localparam int CFG_W = 11;
	localparam int VAL_W = 18;
	localparam int FRAC_BITS = 16;

	// divider operand widths: den = r * k, num = (m << 16) + den / 2
	localparam int DEN_W = 2 * CFG_W;
	localparam int NUM_W = CFG_W + FRAC_BITS + 1;
	localparam int QUO_W = FRAC_BITS + 1;

	// default sizes for the top level parameters
	localparam int MAX_TRAIN_DEF = 1024;
	localparam int LABEL_BITS_DEF = 8;

	// depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// config register reset values
	localparam logic [CFG_W-1:0] K_NEIGHBORS_RST = 11'd1;
	localparam logic [CFG_W-1:0] TRAIN_COUNT_RST = 11'd1024;

	// saturation bounds of the q2.16 value, at one bit of headroom
	localparam logic signed [VAL_W:0] SUM_MAX = 19'sd131071;
	localparam logic signed [VAL_W:0] SUM_MIN = -19'sd131072;

	// apb register select (address bit 2)
	typedef enum logic {
		REG_K_NEIGHBORS = 1'b0,
		REG_TRAIN_COUNT = 1'b1
	} reg_sel_t;

	// item kinds
	typedef enum logic {
		ACTION_LOAD     = 1'b0,
		ACTION_NEIGHBOR = 1'b1
	} action_t;

	// change of the match bit against the previous neighbour
	typedef enum logic [1:0] {
		DELTA_HOLD = 2'd0,
		DELTA_UP   = 2'd1,
		DELTA_DOWN = 2'd2
	} delta_t;

	// back end sequencer
	typedef enum logic [1:0] {
		BACK_IDLE = 2'd0,
		BACK_DIV  = 2'd1,
		BACK_HOLD = 2'd2
	} back_state_t;

	// one classified neighbour, handed from front to back
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             first;
		logic             done;
		logic             match;
		delta_t           delta;
		logic [CFG_W-1:0] m;
		logic [DEN_W-1:0] den;
	} job_t;

	// request to the serial divider
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

endpackage

/* src/ksv_item_if.sv */
// input channel of the knn shapley recursion unit
// depends on ksv_pkg for field widths
interface ksv_item_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [ksv_pkg::IDX_W-1:0]   train_index;
	logic [ksv_pkg::LAB_W-1:0]   label;

	modport source (output valid, action, train_index, label, input ready);
	modport sink (input valid, action, train_index, label, output ready);
endinterface

/* src/ksv_result_if.sv */
// result channel of the knn shapley recursion unit
// depends on ksv_pkg for field widths
interface ksv_result_if;
	logic                             valid;
	logic                             ready;
	logic [ksv_pkg::IDX_W-1:0]        point_index;
	logic signed [ksv_pkg::VAL_W-1:0] shapley_value;
	logic                             test_done;

	modport source (output valid, point_index, shapley_value, test_done, input ready);
	modport sink (input valid, point_index, shapley_value, test_done, output ready);
endinterface

/* src/ksv_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module ksv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/ksv_front.sv */
// front end: accepts items, keeps the label store, ranks and classifies neighbours
// depends on ksv_pkg, ksv_item_if and ksv_ram
module ksv_front #(
	parameter int MAX_TRAIN = ksv_pkg::MAX_TRAIN_DEF,
	parameter int LABEL_BITS = ksv_pkg::LABEL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ksv_item_if.sink                    items,
	input  logic [ksv_pkg::CFG_W-1:0]   k_neighbors,
	input  logic [ksv_pkg::CFG_W-1:0]   train_count,
	output logic                        push,
	output ksv_pkg::job_t               push_job,
	input  logic                        full
);

	localparam int CW_ = ksv_pkg::CFG_W;
	localparam int AW = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
	localparam int XW = ((AW + 1) > (ksv_pkg::IDX_W + 1)) ? (AW + 1) : (ksv_pkg::IDX_W + 1);
	localparam int LW = (LABEL_BITS > ksv_pkg::LAB_W) ? LABEL_BITS : ksv_pkg::LAB_W;

	logic                    accept;
	logic                    load;
	logic                    neighbor;
	logic [XW-1:0]           idx_ext;
	logic                    idx_in_range;
	logic [AW-1:0]           addr;
	logic [LW-1:0]           lab_ext;
	logic [LABEL_BITS-1:0]   lab_m;
	logic [CW_-1:0]          n_eff;
	logic [CW_-1:0]          k_eff;
	logic                    seen_below_n;
	logic [CW_-1:0]          rank;
	logic [CW_-1:0]          r;
	logic [CW_-1:0]          m;
	logic                    done;
	logic                    first;
	logic [LABEL_BITS-1:0]   rdata;
	logic [LABEL_BITS-1:0]   stored;
	logic                    match;
	logic [ksv_pkg::DEN_W-1:0] prod;

	logic [AW-1:0]           items_seen_q;
	logic                    prev_match_q;

	logic                    valid_s1;
	logic [ksv_pkg::IDX_W-1:0] idx_s1;
	logic [LABEL_BITS-1:0]   lab_s1;
	logic                    in_range_s1;
	logic                    first_s1;
	logic                    done_s1;
	logic [CW_-1:0]          r_s1;
	logic [CW_-1:0]          k_s1;
	logic [CW_-1:0]          m_s1;
	logic [CW_-1:0]          n_s1;

	// handshake: take an item when stage 1 is free or moves on
	assign push = valid_s1 && !full;
	assign items.ready = !valid_s1 || !full;
	assign accept = items.valid && items.ready;
	assign load = accept && (items.action == ksv_pkg::ACTION_LOAD);
	assign neighbor = accept && (items.action == ksv_pkg::ACTION_NEIGHBOR);

	// store address and label masked to the stored width
	assign idx_ext = XW'(items.train_index);
	assign idx_in_range = idx_ext < XW'(MAX_TRAIN);
	assign addr = idx_ext[AW-1:0];
	assign lab_ext = LW'(items.label);
	assign lab_m = lab_ext[LABEL_BITS-1:0];

	// effective k and n
	always_comb begin
		k_eff = (k_neighbors == '0) ? CW_'(1) : k_neighbors;
		if (train_count == '0) begin
			n_eff = CW_'(1);
		end else if (XW'(train_count) > XW'(MAX_TRAIN)) begin
			n_eff = CW_'(MAX_TRAIN);
		end else begin
			n_eff = train_count;
		end
	end

	// rank of the incoming neighbour and its min(k, r)
	always_comb begin
		seen_below_n = XW'(items_seen_q) < XW'(n_eff);
		rank = seen_below_n ? (n_eff - CW_'(1) - CW_'(items_seen_q)) : '0;
		done = (rank == '0);
		first = (items_seen_q == '0);
		r = rank + CW_'(1);
		m = (r < k_eff) ? r : k_eff;
	end

	// label store
	ksv_ram #(
		.WIDTH(LABEL_BITS),
		.DEPTH(MAX_TRAIN)
	) u_label_ram (
		.clk   (clk),
		.we    (load && idx_in_range),
		.waddr (addr),
		.wdata (lab_m),
		.re    (neighbor),
		.raddr (addr),
		.rdata (rdata)
	);

	// position within the test point and last match bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_seen_q <= '0;
			prev_match_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (neighbor) begin
				items_seen_q <= done ? '0 : (items_seen_q + AW'(1));
			end
			if (push) begin
				prev_match_q <= match;
			end
			if (neighbor) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (neighbor) begin
			idx_s1 <= items.train_index;
			lab_s1 <= lab_m;
			in_range_s1 <= idx_in_range;
			first_s1 <= first;
			done_s1 <= done;
			r_s1 <= r;
			k_s1 <= k_eff;
			m_s1 <= m;
			n_s1 <= n_eff;
		end
	end

	// stage 1: compare with the stored label and form the divisor
	always_comb begin
		stored = in_range_s1 ? rdata : '0;
		match = (stored == lab_s1);
		prod = ksv_pkg::DEN_W'(r_s1) * ksv_pkg::DEN_W'(k_s1);
		push_job.idx = idx_s1;
		push_job.first = first_s1;
		push_job.done = done_s1;
		push_job.match = match;
		if (match && !prev_match_q) begin
			push_job.delta = ksv_pkg::DELTA_UP;
		end else if (!match && prev_match_q) begin
			push_job.delta = ksv_pkg::DELTA_DOWN;
		end else begin
			push_job.delta = ksv_pkg::DELTA_HOLD;
		end
		push_job.m = first_s1 ? CW_'(1) : m_s1;
		push_job.den = first_s1 ? ksv_pkg::DEN_W'(n_s1) : prod;
	end

endmodule

/* src/ksv_queue.sv */
// short job queue between front and back
// depends on ksv_pkg for the job type
module ksv_queue #(
	parameter int DEPTH = ksv_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ksv_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output ksv_pkg::job_t pop_job,
	output logic          empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	ksv_pkg::job_t  entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [NW-1:0]  count_q;

	assign full = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_job = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : (wr_ptr_q + PW'(1));
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : (rd_ptr_q + PW'(1));
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* src/ksv_divider.sv */
// restoring serial divider, one quotient bit per cycle
// depends on ksv_pkg for operand widths and the request type
module ksv_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ksv_pkg::div_req_t           req,
	output logic                        busy,
	output logic [ksv_pkg::QUO_W-1:0]   quotient
);

	localparam int DW = ksv_pkg::DEN_W;
	localparam int QW = ksv_pkg::QUO_W;
	localparam int NW = ksv_pkg::NUM_W;
	localparam int CNTW = $clog2(QW + 1);

	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [QW-1:0]   quo_q;
	logic [DW:0]     trial;
	logic            fits;

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, quo_q[QW-1]};
		fits = (trial >= {1'b0, den_q});
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= CNTW'(QW);
		end else if (busy) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	// remainder and quotient shift register; the top bits seed the remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DW'(req.num[NW-1:QW]);
			quo_q <= req.num[QW-1:0];
			den_q <= req.den;
		end else if (busy) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

endmodule

/* src/ksv_back.sv */
// back end: takes jobs, divides out the rank term, runs the value recursion
// depends on ksv_pkg and ksv_result_if; drives the divider
module ksv_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  ksv_pkg::job_t               job,
	output logic                        pop,
	output ksv_pkg::div_req_t           div_req,
	input  logic                        div_busy,
	input  logic [ksv_pkg::QUO_W-1:0]   quotient,
	ksv_result_if.source                results
);

	localparam int VW = ksv_pkg::VAL_W;

	ksv_pkg::back_state_t state_q;
	ksv_pkg::back_state_t state_d;
	ksv_pkg::job_t        job_q;
	logic signed [VW-1:0] prev_value_q;
	logic                 out_valid_q;
	logic [ksv_pkg::IDX_W-1:0] out_idx_q;
	logic signed [VW-1:0] out_value_q;
	logic                 out_done_q;

	logic                 load_out;
	logic signed [VW:0]   quo_ext;
	logic signed [VW:0]   prev_ext;
	logic signed [VW:0]   sum;
	logic signed [VW-1:0] value;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ksv_pkg::BACK_IDLE: begin
				if (job_valid) begin
					state_d = ksv_pkg::BACK_DIV;
				end
			end
			ksv_pkg::BACK_DIV: begin
				if (!div_busy) begin
					state_d = ksv_pkg::BACK_HOLD;
				end
			end
			ksv_pkg::BACK_HOLD: begin
				if (!out_valid_q || results.ready) begin
					state_d = ksv_pkg::BACK_IDLE;
				end
			end
			default: begin
				state_d = ksv_pkg::BACK_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pop = (state_q == ksv_pkg::BACK_IDLE) && job_valid;
		load_out = (state_q == ksv_pkg::BACK_HOLD) && (!out_valid_q || results.ready);
	end

	// divider request: rounded numerator (m << 16) + den / 2
	always_comb begin
		div_req.start = pop;
		div_req.den = job.den;
		div_req.num = (ksv_pkg::NUM_W'(job.m) << ksv_pkg::FRAC_BITS)
			+ ksv_pkg::NUM_W'(job.den >> 1);
	end

	// value recursion with saturation
	always_comb begin
		quo_ext = signed'((VW + 1)'(quotient));
		prev_ext = (VW + 1)'(prev_value_q);
		if (job_q.first) begin
			sum = job_q.match ? quo_ext : '0;
		end else begin
			case (job_q.delta)
				ksv_pkg::DELTA_UP: sum = prev_ext + quo_ext;
				ksv_pkg::DELTA_DOWN: sum = prev_ext - quo_ext;
				default: sum = prev_ext;
			endcase
		end
		if (sum > ksv_pkg::SUM_MAX) begin
			value = ksv_pkg::SUM_MAX[VW-1:0];
		end else if (sum < ksv_pkg::SUM_MIN) begin
			value = ksv_pkg::SUM_MIN[VW-1:0];
		end else begin
			value = sum[VW-1:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ksv_pkg::BACK_IDLE;
			prev_value_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				prev_value_q <= value;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// job and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (load_out) begin
			out_idx_q <= job_q.idx;
			out_value_q <= value;
			out_done_q <= job_q.done;
		end
	end

	assign results.valid = out_valid_q;
	assign results.point_index = out_idx_q;
	assign results.shapley_value = out_value_q;
	assign results.test_done = out_done_q;

endmodule

/* src/knn_shapley_value_recursion_unit.sv */
// Exact knn shapley recursion unit. Load items (action 0) write a training label into the
// label store; a slot must be loaded before a neighbour item reads it.
// Neighbour items (action 1) arrive farthest first, one test point after another; each
// yields one result with its index, the saturated q2.16 value and test_done on the nearest.
// A neighbour item's time is set by the 17-step serial divider in the back end that forms
// the rounded rank term; the front end keeps accepting into a two-entry queue and the
// result register holds a finished value while the next one is computed. Registers over
// apb: k_neighbors at 0x0, train_count at 0x4; the user writes only while idle, unenforced.
// Depends on ksv_pkg, ksv_item_if, ksv_result_if, ksv_ram, ksv_front, ksv_queue,
// ksv_divider and ksv_back.
module knn_shapley_value_recursion_unit #(
	parameter int MAX_TRAIN = ksv_pkg::MAX_TRAIN_DEF,
	parameter int LABEL_BITS = ksv_pkg::LABEL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ksv_item_if.sink    items,
	ksv_result_if.source results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [ksv_pkg::CFG_W-1:0] k_neighbors_q;
	logic [ksv_pkg::CFG_W-1:0] train_count_q;
	logic                      cfg_write;
	ksv_pkg::reg_sel_t         reg_sel;

	logic                      push;
	ksv_pkg::job_t             push_job;
	logic                      q_full;
	logic                      pop;
	ksv_pkg::job_t             pop_job;
	logic                      q_empty;
	ksv_pkg::div_req_t         div_req;
	logic                      div_busy;
	logic [ksv_pkg::QUO_W-1:0] quotient;

	// apb register file
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_sel = ksv_pkg::reg_sel_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_neighbors_q <= ksv_pkg::K_NEIGHBORS_RST;
			train_count_q <= ksv_pkg::TRAIN_COUNT_RST;
		end else if (cfg_write) begin
			case (reg_sel)
				ksv_pkg::REG_K_NEIGHBORS: k_neighbors_q <= pwdata[ksv_pkg::CFG_W-1:0];
				ksv_pkg::REG_TRAIN_COUNT: train_count_q <= pwdata[ksv_pkg::CFG_W-1:0];
				default: k_neighbors_q <= k_neighbors_q;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_sel)
			ksv_pkg::REG_K_NEIGHBORS: prdata = 32'(k_neighbors_q);
			ksv_pkg::REG_TRAIN_COUNT: prdata = 32'(train_count_q);
			default: prdata = '0;
		endcase
	end

	// front end
	ksv_front #(
		.MAX_TRAIN(MAX_TRAIN),
		.LABEL_BITS(LABEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.k_neighbors (k_neighbors_q),
		.train_count (train_count_q),
		.push        (push),
		.push_job    (push_job),
		.full        (q_full)
	);

	// job queue
	ksv_queue #(
		.DEPTH(ksv_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	// back end and its divider
	ksv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_empty),
		.job       (pop_job),
		.pop       (pop),
		.div_req   (div_req),
		.div_busy  (div_busy),
		.quotient  (quotient),
		.results   (results)
	);

	ksv_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// front never pushes into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("job pushed into full queue");

	// a popped job starts the divider on the next cycle
	a_pop_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> div_busy)
		else $error("divider idle after job pop");

	// no job is taken while the divider is still working
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !pop)
		else $error("job popped during division");

endmodule

/* bench/ksv_shapley_checker.sv */
// checker of the knn shapley recursion unit: watches the item, result and apb ports,
// predicts each neighbour's saturated q2.16 value and compares it with the result stream
// depends on ksv_pkg, ksv_item_if and ksv_result_if
module ksv_shapley_checker
	import ksv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ksv_item_if         items,
	ksv_result_if       results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count = 0,
	output int          pending = 0
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [IDX_W-1:0]        point_index;
		logic signed [VAL_W-1:0] shapley_value;
		logic                    test_done;
	} neighbor_value_t;

	// own copy of the label store, recursion state and registers
	logic [LAB_W-1:0]        label_mem [MAX_TRAIN_DEF];
	logic signed [VAL_W-1:0] last_value;
	logic                    last_match;
	int unsigned             seen_count;
	logic [CFG_W-1:0]        k_reg;
	logic [CFG_W-1:0]        n_reg;
	neighbor_value_t         value_q [$];

	// unsigned division rounded to nearest, halves up
	function automatic longint round_quot(longint num, longint den);
		return (num + den / 2) / den;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int unsigned     n_eff;
		int unsigned     k_eff;
		int unsigned     rank;
		int unsigned     span;
		longint          term;
		longint          sum;
		logic            hit;
		int              errs;
		neighbor_value_t want;
		if (!arst_n) begin
			value_q.delete();
			last_value = '0;
			last_match = 1'b0;
			seen_count = 0;
			k_reg = K_NEIGHBORS_RST;
			n_reg = TRAIN_COUNT_RST;
			pending <= 0;
		end else begin
			errs = 0;

			// register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_sel_t'(paddr[2]))
					REG_K_NEIGHBORS: k_reg = pwdata[CFG_W-1:0];
					REG_TRAIN_COUNT: n_reg = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end

			// each accepted result against the oldest prediction
			if (results.valid && results.ready) begin
				if (value_q.size() == 0) begin
					$error("point_index: expected none, actual %0d", results.point_index);
					errs++;
				end else begin
					want = value_q.pop_front();
					if (results.point_index !== want.point_index) begin
						$error("point_index: expected %0d, actual %0d",
							want.point_index, results.point_index);
						errs++;
					end
					if (results.shapley_value !== want.shapley_value) begin
						$error("shapley_value: expected %0d, actual %0d",
							want.shapley_value, results.shapley_value);
						errs++;
					end
					if (results.test_done !== want.test_done) begin
						$error("test_done: expected %0d, actual %0d",
							want.test_done, results.test_done);
						errs++;
					end
				end
			end

			// label loads, and one recursion step per neighbour item
			if (items.valid && items.ready) begin
				if (items.action == ACTION_LOAD) begin
					label_mem[items.train_index] = items.label;
				end else begin
					n_eff = (n_reg == 0) ? 1 : ((n_reg > MAX_TRAIN_DEF) ? MAX_TRAIN_DEF : n_reg);
					k_eff = (k_reg == 0) ? 1 : k_reg;
					hit = (label_mem[items.train_index] == items.label);
					rank = (seen_count < n_eff) ? n_eff - 1 - seen_count : 0;
					if (seen_count == 0) begin
						sum = hit ? round_quot(longint'(1) << FRAC_BITS, n_eff) : 0;
					end else begin
						span = rank + 1;
						term = round_quot(longint'((span < k_eff) ? span : k_eff) << FRAC_BITS,
							longint'(span) * k_eff);
						sum = last_value;
						if (hit && !last_match) sum = sum + term;
						else if (!hit && last_match) sum = sum - term;
					end
					if (sum > SUM_MAX) sum = SUM_MAX;
					else if (sum < SUM_MIN) sum = SUM_MIN;
					want.point_index = items.train_index;
					want.shapley_value = sum[VAL_W-1:0];
					want.test_done = (rank == 0);
					value_q.push_back(want);
					last_value = sum[VAL_W-1:0];
					last_match = hit;
					seen_count = (rank == 0) ? 0 : seen_count + 1;
				end
			end

			pending <= value_q.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

/* bench/tb_knn_shapley_value_recursion_unit.sv */
// top of the knn shapley recursion unit bench: clock, reset, item and apb stimulus,
// receiver stalls and the verdict; prediction and comparison sit in ksv_shapley_checker
// depends on ksv_pkg, ksv_item_if, ksv_result_if and the unit itself
module tb_knn_shapley_value_recursion_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ksv_pkg::*;

	localparam int TOTAL_ITEMS = 1850;
	localparam int SETTLE_CYCLES = 50;
	localparam int LONG_POINT = 48;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_WAVE
	} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;

	ksv_item_if   item_ch ();
	ksv_result_if result_ch ();

	knn_shapley_value_recursion_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ksv_shapley_checker shapley_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (item_ch),
		.results    (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver stalls: random segments of open, light, heavy or square-wave backpressure
	rx_mode_t    rx_mode;
	int unsigned rx_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_mode = RX_OPEN;
			rx_left = 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 120);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_OPEN:  result_ch.ready <= 1'b1;
				RX_LIGHT: result_ch.ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: result_ch.ready <= ($urandom_range(0, 3) == 0);
				default:  result_ch.ready <= rx_left[3];
			endcase
		end
	end

	// stimulus bookkeeping: loaded slots, position in the test point, burst length
	bit               loaded [MAX_TRAIN_DEF];
	int unsigned      loaded_q [$];
	int unsigned      point_pos = 0;
	int unsigned      items_sent = 0;
	int unsigned      burst_left = 0;
	logic [CFG_W-1:0] n_cfg = TRAIN_COUNT_RST;

	function automatic int unsigned eff_count();
		return (n_cfg == 0) ? 1 : ((n_cfg > MAX_TRAIN_DEF) ? MAX_TRAIN_DEF : n_cfg);
	endfunction

	// mostly a small set of classes so that labels match often
	function automatic logic [LAB_W-1:0] pick_label();
		return ($urandom_range(0, 7) != 0) ? LAB_W'($urandom_range(0, 3)) : LAB_W'($urandom);
	endfunction

	function automatic logic [IDX_W-1:0] any_loaded();
		return IDX_W'(loaded_q[$urandom_range(0, loaded_q.size() - 1)]);
	endfunction

	// one item; waits for its handshake, then maybe a gap between bursts
	task automatic put_item(input action_t act, input logic [IDX_W-1:0] idx,
			input logic [LAB_W-1:0] lab);
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.train_index <= idx;
		item_ch.label <= lab;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		if (act == ACTION_LOAD) begin
			if (!loaded[idx]) begin
				loaded[idx] = 1'b1;
				loaded_q.push_back(idx);
			end
		end else begin
			point_pos = (point_pos + 1 >= eff_count()) ? 0 : point_pos + 1;
		end
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 15);
		end else begin
			burst_left--;
		end
	endtask

	// hold items until every result is back and any load has finished
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup, access, then idle; upper data bits are noise
	task automatic apb_write(input reg_sel_t sel, input logic [CFG_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {21'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (sel == REG_TRAIN_COUNT) n_cfg = val;
		@(posedge clk);
	endtask

	// run timeout
	initial begin
		#8ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned      len;
		int unsigned      k_pick;
		int unsigned      n_pick;
		int unsigned      hit_slot;
		int unsigned      miss_slot;
		bit               climb;
		logic [LAB_W-1:0] test_lab;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.action <= ACTION_LOAD;
		item_ch.train_index <= '0;
		item_ch.label <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// labels at the corners of the index and label ranges
		put_item(ACTION_LOAD, 10'd0, 8'h00);
		put_item(ACTION_LOAD, 10'd1023, 8'hff);
		put_item(ACTION_LOAD, 10'h155, 8'haa);
		put_item(ACTION_LOAD, 10'h2aa, 8'h55);

		// reset registers: farthest of 1024 neighbours
		put_item(ACTION_NEIGHBOR, 10'h155, 8'haa);

		// zero count acts as one and lies below the position: next neighbour closes the point
		settle();
		apb_write(REG_TRAIN_COUNT, 11'd0);
		put_item(ACTION_NEIGHBOR, 10'd1023, 8'h55);

		// zero k acts as one; miss, hit, miss
		settle();
		apb_write(REG_K_NEIGHBORS, 11'd0);
		apb_write(REG_TRAIN_COUNT, 11'd3);
		put_item(ACTION_NEIGHBOR, 10'd1023, 8'haa);
		put_item(ACTION_NEIGHBOR, 10'h155, 8'haa);
		put_item(ACTION_NEIGHBOR, 10'h2aa, 8'haa);

		// count above the store clamps to its size; cut short by a smaller count
		settle();
		apb_write(REG_K_NEIGHBORS, 11'd1024);
		apb_write(REG_TRAIN_COUNT, 11'd2047);
		put_item(ACTION_NEIGHBOR, 10'h2aa, 8'h55);
		put_item(ACTION_NEIGHBOR, 10'd0, 8'h55);
		put_item(ACTION_NEIGHBOR, 10'h155, 8'h55);
		put_item(ACTION_NEIGHBOR, 10'h2aa, 8'h55);
		settle();
		apb_write(REG_TRAIN_COUNT, 11'd2);
		put_item(ACTION_NEIGHBOR, 10'd1023, 8'h55);

		// single-neighbour points with k at the top of its field
		settle();
		apb_write(REG_K_NEIGHBORS, 11'd2047);
		apb_write(REG_TRAIN_COUNT, 11'd1);
		put_item(ACTION_NEIGHBOR, 10'd1023, 8'hff);
		put_item(ACTION_NEIGHBOR, 10'd0, 8'h01);

		// random phases
		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 11) == 0) begin
				// saturation: alternate the count so hits land at rank 1 and misses far out
				climb = $urandom_range(0, 1);
				test_lab = pick_label();
				hit_slot = $urandom_range(0, MAX_TRAIN_DEF - 1);
				miss_slot = (hit_slot + $urandom_range(1, MAX_TRAIN_DEF - 1)) % MAX_TRAIN_DEF;
				put_item(ACTION_LOAD, IDX_W'(hit_slot), test_lab);
				put_item(ACTION_LOAD, IDX_W'(miss_slot),
					test_lab ^ LAB_W'($urandom_range(1, 255)));
				settle();
				apb_write(REG_K_NEIGHBORS, 11'd1);
				apb_write(REG_TRAIN_COUNT, CFG_W'(MAX_TRAIN_DEF));
				put_item(ACTION_NEIGHBOR, IDX_W'(climb ? miss_slot : hit_slot), test_lab);
				repeat (6) begin
					settle();
					apb_write(REG_TRAIN_COUNT, CFG_W'(point_pos + 2));
					put_item(ACTION_NEIGHBOR, IDX_W'(climb ? hit_slot : miss_slot), test_lab);
					settle();
					apb_write(REG_TRAIN_COUNT, CFG_W'(MAX_TRAIN_DEF));
					put_item(ACTION_NEIGHBOR, IDX_W'(climb ? miss_slot : hit_slot), test_lab);
				end
				settle();
				apb_write(REG_TRAIN_COUNT, CFG_W'($urandom_range(0, point_pos)));
				put_item(ACTION_NEIGHBOR, any_loaded(), test_lab);
			end else begin
				// new registers, then a few test points
				case ($urandom_range(0, 7))
					0:       k_pick = 0;
					1:       k_pick = 1;
					2:       k_pick = 1024;
					3:       k_pick = $urandom_range(0, 2047);
					default: k_pick = $urandom_range(2, 16);
				endcase
				case ($urandom_range(0, 9))
					0:       n_pick = 0;
					1:       n_pick = 1;
					2:       n_pick = $urandom_range(1025, 2047);
					3:       n_pick = 1024;
					4:       n_pick = $urandom_range(17, 64);
					default: n_pick = $urandom_range(2, 16);
				endcase
				settle();
				apb_write(REG_K_NEIGHBORS, CFG_W'(k_pick));
				apb_write(REG_TRAIN_COUNT, CFG_W'(n_pick));
				repeat ($urandom_range(1, 4)) begin
					test_lab = pick_label();
					len = eff_count();
					if (len > LONG_POINT) len = $urandom_range(1, 40);
					repeat (len) begin
						if ($urandom_range(0, 6) == 0)
							put_item(ACTION_LOAD, IDX_W'($urandom_range(0, MAX_TRAIN_DEF - 1)),
								pick_label());
						// now and then a neighbour with a stray test label
						if ($urandom_range(0, 19) == 0)
							put_item(ACTION_NEIGHBOR, any_loaded(), pick_label());
						else
							put_item(ACTION_NEIGHBOR, any_loaded(), test_lab);
					end
					// long points end early: count dropped to the position or below
					if (point_pos != 0) begin
						settle();
						apb_write(REG_TRAIN_COUNT, CFG_W'($urandom_range(0, point_pos)));
						put_item(ACTION_NEIGHBOR, any_loaded(), test_lab);
					end
				end
			end
		end

		// drain and verdict
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
